// ===== rtl/wft_pkg.sv =====
// ----------------------------------------------------------------------------
// wft_pkg - shared types and constants of the Wiegand frame transmitter
// Frame geometry, register indexes, reset defaults and the queue item.
// ----------------------------------------------------------------------------
package wft_pkg;

   // frame geometry
   localparam int MAX_DATA_BITS   = 32;
   localparam int SHORT_DATA_BITS = 24;
   localparam int MAX_HALF        = MAX_DATA_BITS / 2;
   localparam int SHORT_HALF      = SHORT_DATA_BITS / 2;
   localparam int FRAME_W         = MAX_DATA_BITS + 2;
   localparam int SHORT_FRAME_W   = SHORT_DATA_BITS + 2;
   localparam int BITS_W          = $clog2(FRAME_W + 1);
   localparam int TICK_W          = 16;

   // register indexes
   localparam logic [1:0] CSR_PULSE_TICKS   = 2'd0;
   localparam logic [1:0] CSR_GAP_TICKS     = 2'd1;
   localparam logic [1:0] CSR_LEAD_TICKS    = 2'd2;
   localparam logic [1:0] CSR_INVERT_LEVELS = 2'd3;

   // register reset values
   localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 16'd400;
   localparam logic [TICK_W-1:0] GAP_TICKS_RST   = 16'd2000;
   localparam logic [TICK_W-1:0] LEAD_TICKS_RST  = 16'd2000;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // classified beat: frame is left aligned, current bit at the MSB
   typedef struct packed {
      logic               is_send;
      logic [FRAME_W-1:0] frame;
      logic [BITS_W-1:0]  nbits;
   } wft_item_type;

   typedef struct packed {
      logic [TICK_W-1:0] pulse_ticks;
      logic [TICK_W-1:0] gap_ticks;
      logic [TICK_W-1:0] lead_ticks;
      logic              invert_levels;
   } wft_cfg_type;

endpackage

// ===== rtl/wft_front.sv =====
// ----------------------------------------------------------------------------
// wft_front - beat classifier
// Splits tick from send beats and builds the parity-framed bit string.
// ----------------------------------------------------------------------------
module wft_front (
   input  logic                       command,
   input  logic                       frame_format,
   input  logic [31:0]                card_data,
   output wft_pkg::wft_item_type      item
);

   logic                              ep_short;
   logic                              op_short;
   logic                              ep_long;
   logic                              op_long;
   logic [wft_pkg::SHORT_FRAME_W-1:0] short_frame;
   logic [wft_pkg::FRAME_W-1:0]       long_frame;

   assign ep_short = ^card_data[wft_pkg::SHORT_DATA_BITS-1:wft_pkg::SHORT_HALF];
   assign op_short = ~^card_data[wft_pkg::SHORT_HALF-1:0];
   assign ep_long  = ^card_data[wft_pkg::MAX_DATA_BITS-1:wft_pkg::MAX_HALF];
   assign op_long  = ~^card_data[wft_pkg::MAX_HALF-1:0];

   assign short_frame = {ep_short, card_data[wft_pkg::SHORT_DATA_BITS-1:0], op_short};
   assign long_frame  = {ep_long, card_data[wft_pkg::MAX_DATA_BITS-1:0], op_long};

   always_comb begin
      item.is_send = (command == wft_pkg::CMD_SEND);
      if (frame_format) begin
         item.frame = long_frame;
         item.nbits = wft_pkg::BITS_W'(wft_pkg::FRAME_W);
      end else begin
         // left align so the first bit sits at the MSB
         item.frame = wft_pkg::FRAME_W'(short_frame)
                      << (wft_pkg::FRAME_W - wft_pkg::SHORT_FRAME_W);
         item.nbits = wft_pkg::BITS_W'(wft_pkg::SHORT_FRAME_W);
      end
   end

endmodule

// ===== rtl/wft_queue.sv =====
// ----------------------------------------------------------------------------
// wft_queue - two-entry queue between classifier and sequencer
// Registered full flag, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module wft_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wft_pkg::wft_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output wft_pkg::wft_item_type pop_item
);

   wft_pkg::wft_item_type entries_ff [2];
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/wft_back.sv =====
// ----------------------------------------------------------------------------
// wft_back - frame timing sequencer
// Runs lead / pulse / gap timing per beat and registers the result beat.
// ----------------------------------------------------------------------------
module wft_back (
   input  logic                  clock,
   input  logic                  reset,
   input  wft_pkg::wft_cfg_type  cfg,
   input  logic                  item_valid,
   input  wft_pkg::wft_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_d0_line,
   output logic                  rsp_d1_line,
   output logic                  rsp_busy_res,
   output logic                  rsp_frame_done,
   output logic                  rsp_send_rejected
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LEAD  = 2'd1;
   localparam logic [1:0] PH_PULSE = 2'd2;
   localparam logic [1:0] PH_GAP   = 2'd3;

   logic [1:0]                   phase_ff, phase_in;
   logic [wft_pkg::TICK_W-1:0]   tick_count_ff, tick_count_in;
   logic [wft_pkg::FRAME_W-1:0]  frame_ff, frame_in;
   logic [wft_pkg::BITS_W-1:0]   bits_left_ff, bits_left_in;
   logic [wft_pkg::BITS_W-1:0]   bits_dec;
   logic [wft_pkg::TICK_W:0]     tick_next;
   logic [wft_pkg::TICK_W-1:0]   pulse_len;
   logic [wft_pkg::TICK_W-1:0]   gap_len;
   logic                         idle_lvl;
   logic                         d0, d1, done, rejected;

   logic rsp_valid_ff;
   logic d0_ff, d1_ff, busy_ff, done_ff, rejected_ff;

   assign item_pop  = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign idle_lvl  = ~cfg.invert_levels;
   assign tick_next = {1'b0, tick_count_ff} + 17'd1;
   assign pulse_len = (cfg.pulse_ticks == '0) ? wft_pkg::TICK_W'(1) : cfg.pulse_ticks;
   assign gap_len   = (cfg.gap_ticks == '0) ? wft_pkg::TICK_W'(1) : cfg.gap_ticks;
   assign bits_dec  = (bits_left_ff != '0) ? bits_left_ff - 1'b1 : bits_left_ff;

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      frame_in      = frame_ff;
      bits_left_in  = bits_left_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      d0            = idle_lvl;
      d1            = idle_lvl;

      // lines show the level in force before this beat
      if (phase_ff == PH_PULSE) begin
         if (frame_ff[wft_pkg::FRAME_W-1])
            d1 = ~idle_lvl;
         else
            d0 = ~idle_lvl;
      end

      if (item.is_send) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            frame_in      = item.frame;
            bits_left_in  = item.nbits;
            tick_count_in = '0;
            phase_in      = (cfg.lead_ticks == '0) ? PH_PULSE : PH_LEAD;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_LEAD: begin
               if (tick_next >= {1'b0, cfg.lead_ticks}) begin
                  phase_in      = PH_PULSE;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = tick_next[wft_pkg::TICK_W-1:0];
               end
            end
            PH_PULSE: begin
               if (tick_next >= {1'b0, pulse_len}) begin
                  phase_in      = PH_GAP;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = tick_next[wft_pkg::TICK_W-1:0];
               end
            end
            PH_GAP: begin
               if (tick_next >= {1'b0, gap_len}) begin
                  tick_count_in = '0;
                  bits_left_in  = bits_dec;
                  frame_in      = frame_ff << 1;
                  if (bits_dec == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_PULSE;
                  end
               end else begin
                  tick_count_in = tick_next[wft_pkg::TICK_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bits_left_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            bits_left_ff  <= bits_left_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         frame_ff    <= frame_in;
         d0_ff       <= d0;
         d1_ff       <= d1;
         busy_ff     <= (phase_in != PH_IDLE);
         done_ff     <= done;
         rejected_ff <= rejected;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_d0_line       = d0_ff;
   assign rsp_d1_line       = d1_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_send_rejected = rejected_ff;

endmodule

// ===== rtl/wiegand_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// wiegand_frame_transmitter - Wiegand 26/34-bit frame transmitter
// Tick and send beats in, one line-level status beat out per input beat.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: command 1 starts a frame (frame_format 0 = 26-bit,
//    1 = 34-bit, card_data is the payload); command 0 is one time tick.
//  - rsp channel: one beat per req beat, in order, carrying both line
//    levels seen by that beat, busy, frame done and send rejected.
//  - csr port: single-cycle writes of pulse, gap, lead length and polarity;
//    write only while no beat is in flight.
//  - A req beat is written into the queue and then popped into the response
//    register of the sequencer, which raises rsp_valid.
//  - Throughput: one beat per cycle while rsp_stall is low; the sequencer
//    updates its timing state once per beat.
//  - A two-entry queue sits between classifier and sequencer; req_stall is
//    its registered full flag, so a rsp stall backs up the queue and stalls
//    req once the queue holds two beats.
//  - Reset clears the frame state, empties the queue and restores register
//    defaults (400 / 2000 / 2000 ticks, idle high).
// ----------------------------------------------------------------------------
module wiegand_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_frame_format,
   input  logic [31:0] req_card_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_d0_line,
   output logic        rsp_d1_line,
   output logic        rsp_busy_res,
   output logic        rsp_frame_done,
   output logic        rsp_send_rejected,
   // configuration write port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   wft_pkg::wft_cfg_type  cfg_ff;
   wft_pkg::wft_item_type front_item;
   wft_pkg::wft_item_type queue_item;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  queue_pop;
   logic                  req_beat;

   assign req_stall = queue_full;
   assign req_beat  = req_valid && !queue_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks   <= wft_pkg::PULSE_TICKS_RST;
         cfg_ff.gap_ticks     <= wft_pkg::GAP_TICKS_RST;
         cfg_ff.lead_ticks    <= wft_pkg::LEAD_TICKS_RST;
         cfg_ff.invert_levels <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wft_pkg::CSR_PULSE_TICKS:   cfg_ff.pulse_ticks   <= csr_write_data;
            wft_pkg::CSR_GAP_TICKS:     cfg_ff.gap_ticks     <= csr_write_data;
            wft_pkg::CSR_LEAD_TICKS:    cfg_ff.lead_ticks    <= csr_write_data;
            wft_pkg::CSR_INVERT_LEVELS: cfg_ff.invert_levels <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // front: classify beat and build the framed bit string
   wft_front u_front (
      .command      (req_command),
      .frame_format (req_frame_format),
      .card_data    (req_card_data),
      .item         (front_item)
   );

   wft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_beat),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   // back: timing sequencer and response register
   wft_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .item_valid        (queue_not_empty),
      .item              (queue_item),
      .item_pop          (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_d0_line       (rsp_d0_line),
      .rsp_d1_line       (rsp_d1_line),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_send_rejected (rsp_send_rejected)
   );

   // completion beat never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res)
      else $error("frame_done with busy set");

   // a rejected send only happens mid-frame, and the frame carries on
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_rejected |-> rsp_busy_res && !rsp_frame_done)
      else $error("send rejected while idle");

   // at most one line is driven active at a time
   a_one_line_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_d0_line == ~cfg_ff.invert_levels) ||
                    (rsp_d1_line == ~cfg_ff.invert_levels))
      else $error("both data lines active");

   // a popped beat always comes from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_not_empty)
      else $error("queue popped while empty");

endmodule
